@@ sv/vbs_pkg.sv @@
// shared types, codes and reset values for the vibration burst sequencer
package vbs_pkg;

    localparam int TICK_W     = 10;
    localparam int ON_CNT_W   = 26;
    localparam int CYCLE_W    = 18;
    localparam int DUR_W      = 16;
    localparam int CFG_IDX_W  = 3;

    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [ON_CNT_W-1:0]  on_cnt_t;
    typedef logic [CYCLE_W-1:0]   cycle_t;
    typedef logic [DUR_W-1:0]     dur_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [1:0]           code_t;

    // request codes
    localparam code_t REQ_TICK  = 2'd0;
    localparam code_t REQ_START = 2'd1;
    localparam code_t REQ_STOP  = 2'd2;

    // levels
    localparam code_t LVL_1HZ  = 2'd0;
    localparam code_t LVL_2HZ  = 2'd1;
    localparam code_t LVL_4HZ  = 2'd2;
    localparam code_t LVL_CONT = 2'd3;

    // status codes
    localparam code_t ST_OK      = 2'd0;
    localparam code_t ST_BUSY    = 2'd1;
    localparam code_t ST_INVALID = 2'd2;

    // phase codes
    localparam code_t PH_IDLE = 2'd0;
    localparam code_t PH_ON   = 2'd1;
    localparam code_t PH_OFF  = 2'd2;

    // register indexes
    localparam cfg_idx_t REG_ON_1HZ    = 3'd0;
    localparam cfg_idx_t REG_OFF_1HZ   = 3'd1;
    localparam cfg_idx_t REG_ON_2HZ    = 3'd2;
    localparam cfg_idx_t REG_OFF_2HZ   = 3'd3;
    localparam cfg_idx_t REG_ON_4HZ    = 3'd4;
    localparam cfg_idx_t REG_OFF_4HZ   = 3'd5;
    localparam cfg_idx_t REG_KEEP_ON   = 3'd6;
    localparam cfg_idx_t REG_KEEP_OFF  = 3'd7;

    // register reset values
    localparam tick_t RST_ON_1HZ   = 10'd5;
    localparam tick_t RST_OFF_1HZ  = 10'd5;
    localparam tick_t RST_ON_2HZ   = 10'd3;
    localparam tick_t RST_OFF_2HZ  = 10'd2;
    localparam tick_t RST_ON_4HZ   = 10'd1;
    localparam tick_t RST_OFF_4HZ  = 10'd1;
    localparam tick_t RST_KEEP_ON  = 10'd10;
    localparam tick_t RST_KEEP_OFF = 10'd0;

    localparam cycle_t RST_CYCLE_LIMIT = 18'd3;

    typedef struct packed {
        tick_t on_1hz;
        tick_t off_1hz;
        tick_t on_2hz;
        tick_t off_2hz;
        tick_t on_4hz;
        tick_t off_4hz;
        tick_t keep_on;
        tick_t keep_off;
    } cfg_regs_t;

    typedef struct packed {
        code_t req_type;
        code_t level;
        dur_t  duration_sec;
    } req_t;

    typedef struct packed {
        logic  motor_drive;
        code_t status;
        code_t phase;
    } rsp_t;

endpackage

@@ sv/vbs_ifs.sv @@
// handshake channels of the vibration burst sequencer

interface vbs_req_if;
    logic               valid;
    logic               ready;
    vbs_pkg::code_t     req_type;
    vbs_pkg::code_t     level;
    vbs_pkg::dur_t      duration_sec;

    modport source (output valid, output req_type, output level, output duration_sec,
                    input ready);
    modport sink   (input valid, input req_type, input level, input duration_sec,
                    output ready);
endinterface

interface vbs_rsp_if;
    logic               valid;
    logic               ready;
    logic               motor_drive;
    vbs_pkg::code_t     status;
    vbs_pkg::code_t     phase;

    modport source (output valid, output motor_drive, output status, output phase,
                    input ready);
    modport sink   (input valid, input motor_drive, input status, input phase,
                    output ready);
endinterface

interface vbs_cfg_if;
    logic               valid;
    logic               ready;
    vbs_pkg::cfg_idx_t  index;
    vbs_pkg::tick_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/vibration_burst_sequencer.sv @@
// top level of the vibration burst sequencer
// Drives a vibration motor in timed on/off bursts. Every item on req gives exactly
// one item on rsp, in order. A start item picks a level (1 Hz, 2 Hz, 4 Hz or
// continuous) and a duration in seconds; a start while a burst runs answers busy,
// a start with zero duration answers invalid, and neither changes anything. Tick
// items step the on count, then the off count, then the cycle count; a stop item
// returns to idle at once. The response shows the phase and motor drive after the
// item has been applied. Throughput is one item per clock while rsp.ready is high: an item
// waits in the input register, then a single pass of count compare and update (with one
// 10 x 16 bit multiply for the continuous level) writes the burst state and the
// response register together once that register is empty or being drained, which
// raises rsp.valid; the response stays there until rsp.ready takes it.
// The response register frees the input side: a new request is taken while an
// earlier response still waits on rsp.ready. Configuration registers are written
// through cfg (always ready) and are read only when a start is applied, so they
// should be written while the block is idle.
module vibration_burst_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    vbs_req_if.sink    req,
    vbs_rsp_if.source  rsp,
    vbs_cfg_if.sink    cfg
);

    // input register
    logic           in_valid_reg, in_valid_next;
    vbs_pkg::req_t  in_item_reg,  in_item_next;

    // response register
    logic           out_valid_reg, out_valid_next;
    vbs_pkg::rsp_t  out_item_reg,  out_item_next;

    logic               req_take;
    logic               advance;
    vbs_pkg::rsp_t      core_result;
    vbs_pkg::cfg_regs_t regs;

    // the stage moves on whenever the response register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_take = req.valid && req.ready;

    assign cfg.ready = 1'b1;

    vbs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .regs     (regs)
    );

    vbs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .regs   (regs),
        .result (core_result)
    );

    always_comb
    begin
        in_item_next = in_item_reg;
        if (req_take)
        begin
            in_item_next.req_type     = req.req_type;
            in_item_next.level        = req.level;
            in_item_next.duration_sec = req.duration_sec;
        end

        if (req_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        out_item_next = advance ? core_result : out_item_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.motor_drive = out_item_reg.motor_drive;
    assign rsp.status      = out_item_reg.status;
    assign rsp.phase       = out_item_reg.phase;

`ifndef SYNTH
    // motor is powered exactly in the on phase
    a_motor_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.motor_drive == (out_item_reg.phase == vbs_pkg::PH_ON)))
        else $error("motor drive disagrees with phase");

    // busy only comes back while a burst runs, invalid only while idle
    a_busy_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status == vbs_pkg::ST_BUSY)
            |-> (out_item_reg.phase != vbs_pkg::PH_IDLE))
        else $error("busy status while idle");

    a_invalid_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status == vbs_pkg::ST_INVALID)
            |-> (out_item_reg.phase == vbs_pkg::PH_IDLE))
        else $error("invalid status while a burst runs");

    // a stalled request stays in the input register
    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("stalled request lost");
`endif

endmodule

@@ sv/vbs_cfg_regs.sv @@
// tick count configuration registers
module vbs_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  vbs_pkg::cfg_idx_t   wr_index,
    input  vbs_pkg::tick_t      wr_data,
    output vbs_pkg::cfg_regs_t  regs
);

    vbs_pkg::cfg_regs_t regs_reg;
    vbs_pkg::cfg_regs_t regs_next;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                vbs_pkg::REG_ON_1HZ:   regs_next.on_1hz   = wr_data;
                vbs_pkg::REG_OFF_1HZ:  regs_next.off_1hz  = wr_data;
                vbs_pkg::REG_ON_2HZ:   regs_next.on_2hz   = wr_data;
                vbs_pkg::REG_OFF_2HZ:  regs_next.off_2hz  = wr_data;
                vbs_pkg::REG_ON_4HZ:   regs_next.on_4hz   = wr_data;
                vbs_pkg::REG_OFF_4HZ:  regs_next.off_4hz  = wr_data;
                vbs_pkg::REG_KEEP_ON:  regs_next.keep_on  = wr_data;
                vbs_pkg::REG_KEEP_OFF: regs_next.keep_off = wr_data;
                default:               regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.on_1hz   <= vbs_pkg::RST_ON_1HZ;
            regs_reg.off_1hz  <= vbs_pkg::RST_OFF_1HZ;
            regs_reg.on_2hz   <= vbs_pkg::RST_ON_2HZ;
            regs_reg.off_2hz  <= vbs_pkg::RST_OFF_2HZ;
            regs_reg.on_4hz   <= vbs_pkg::RST_ON_4HZ;
            regs_reg.off_4hz  <= vbs_pkg::RST_OFF_4HZ;
            regs_reg.keep_on  <= vbs_pkg::RST_KEEP_ON;
            regs_reg.keep_off <= vbs_pkg::RST_KEEP_OFF;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

@@ sv/vbs_core.sv @@
// burst state registers and the per-item update of phase, counts and limits
module vbs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  vbs_pkg::req_t       item,
    input  vbs_pkg::cfg_regs_t  regs,
    output vbs_pkg::rsp_t       result
);

    vbs_pkg::code_t   phase_reg,       phase_next;
    vbs_pkg::on_cnt_t on_count_reg,    on_count_next;
    vbs_pkg::tick_t   off_count_reg,   off_count_next;
    vbs_pkg::cycle_t  cycle_count_reg, cycle_count_next;
    vbs_pkg::on_cnt_t on_limit_reg,    on_limit_next;
    vbs_pkg::tick_t   off_limit_reg,   off_limit_next;
    vbs_pkg::cycle_t  cycle_limit_reg, cycle_limit_next;

    vbs_pkg::code_t   status;
    vbs_pkg::on_cnt_t on_inc;
    vbs_pkg::tick_t   off_inc;
    vbs_pkg::cycle_t  cycle_inc;
    vbs_pkg::on_cnt_t keep_on_total;

    assign on_inc    = on_count_reg + 1'b1;
    assign off_inc   = off_count_reg + 1'b1;
    assign cycle_inc = cycle_count_reg + 1'b1;

    // 10 x 16 bit product fits the on counter exactly
    assign keep_on_total = {{(vbs_pkg::ON_CNT_W - vbs_pkg::TICK_W){1'b0}}, regs.keep_on}
                         * {{(vbs_pkg::ON_CNT_W - vbs_pkg::DUR_W){1'b0}}, item.duration_sec};

    always_comb
    begin
        phase_next       = phase_reg;
        on_count_next    = on_count_reg;
        off_count_next   = off_count_reg;
        cycle_count_next = cycle_count_reg;
        on_limit_next    = on_limit_reg;
        off_limit_next   = off_limit_reg;
        cycle_limit_next = cycle_limit_reg;
        status           = vbs_pkg::ST_OK;

        case (item.req_type)
            vbs_pkg::REQ_TICK:
            begin
                if (phase_reg == vbs_pkg::PH_ON)
                begin
                    on_count_next = on_inc;
                    if (on_inc >= on_limit_reg)
                        phase_next = vbs_pkg::PH_OFF;
                end
                else if (phase_reg == vbs_pkg::PH_OFF)
                begin
                    off_count_next = off_inc;
                    if (off_inc >= off_limit_reg)
                    begin
                        on_count_next  = '0;
                        off_count_next = '0;
                        if (cycle_inc >= cycle_limit_reg)
                        begin
                            // last cycle done
                            cycle_count_next = '0;
                            phase_next       = vbs_pkg::PH_IDLE;
                        end
                        else
                        begin
                            cycle_count_next = cycle_inc;
                            phase_next       = vbs_pkg::PH_ON;
                        end
                    end
                end
                else
                begin
                    phase_next       = vbs_pkg::PH_IDLE;
                    on_count_next    = '0;
                    off_count_next   = '0;
                    cycle_count_next = '0;
                end
            end
            vbs_pkg::REQ_START:
            begin
                if (phase_reg != vbs_pkg::PH_IDLE)
                    status = vbs_pkg::ST_BUSY;
                else if (item.duration_sec == '0)
                    status = vbs_pkg::ST_INVALID;
                else
                begin
                    case (item.level)
                        vbs_pkg::LVL_1HZ:
                        begin
                            cycle_limit_next = {2'b00, item.duration_sec};
                            on_limit_next    = {16'd0, regs.on_1hz};
                            off_limit_next   = regs.off_1hz;
                        end
                        vbs_pkg::LVL_2HZ:
                        begin
                            cycle_limit_next = {1'b0, item.duration_sec, 1'b0};
                            on_limit_next    = {16'd0, regs.on_2hz};
                            off_limit_next   = regs.off_2hz;
                        end
                        vbs_pkg::LVL_4HZ:
                        begin
                            cycle_limit_next = {item.duration_sec, 2'b00};
                            on_limit_next    = {16'd0, regs.on_4hz};
                            off_limit_next   = regs.off_4hz;
                        end
                        default:
                        begin
                            cycle_limit_next = 18'd1;
                            on_limit_next    = keep_on_total;
                            off_limit_next   = regs.keep_off;
                        end
                    endcase
                    on_count_next    = '0;
                    off_count_next   = '0;
                    cycle_count_next = '0;
                    phase_next       = vbs_pkg::PH_ON;
                end
            end
            vbs_pkg::REQ_STOP:
            begin
                phase_next       = vbs_pkg::PH_IDLE;
                on_count_next    = '0;
                off_count_next   = '0;
                cycle_count_next = '0;
            end
            default:
            begin
                // unused request code: no change
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= vbs_pkg::PH_IDLE;
            on_count_reg    <= '0;
            off_count_reg   <= '0;
            cycle_count_reg <= '0;
            on_limit_reg    <= {16'd0, vbs_pkg::RST_ON_1HZ};
            off_limit_reg   <= vbs_pkg::RST_OFF_1HZ;
            cycle_limit_reg <= vbs_pkg::RST_CYCLE_LIMIT;
        end
        else if (en)
        begin
            phase_reg       <= phase_next;
            on_count_reg    <= on_count_next;
            off_count_reg   <= off_count_next;
            cycle_count_reg <= cycle_count_next;
            on_limit_reg    <= on_limit_next;
            off_limit_reg   <= off_limit_next;
            cycle_limit_reg <= cycle_limit_next;
        end
    end

    assign result.motor_drive = (phase_next == vbs_pkg::PH_ON);
    assign result.status      = status;
    assign result.phase       = phase_next;

endmodule

@@ bench/vibration_burst_sequencer_tb.sv @@
// self-checking testbench for the vibration burst sequencer: predicted responses vs the block
module vibration_burst_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // clock, run length and stall shaping
    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 100;      // long receiver stall, fills the block
    localparam int TIMEOUT_CYCLES   = 400000;
    localparam int NUM_SETTINGS     = 6;
    localparam int ITEMS_PER_SET    = 335;

    // request code the block has no use for, it must be ignored
    localparam vbs_pkg::code_t REQ_UNUSED = 2'd3;

    typedef vbs_pkg::tick_t reg_file_t [8];

    // tracks burst state from accepted items and holds the responses still owed
    class burst_scoreboard;
        vbs_pkg::tick_t   regs [8];
        vbs_pkg::code_t   phase_now;
        vbs_pkg::on_cnt_t on_cnt;
        vbs_pkg::on_cnt_t on_lim;
        vbs_pkg::tick_t   off_cnt;
        vbs_pkg::tick_t   off_lim;
        vbs_pkg::cycle_t  cyc_cnt;
        vbs_pkg::cycle_t  cyc_lim;
        vbs_pkg::rsp_t    owed_rsp_q [$];
        int               errors;

        function new();
            regs[vbs_pkg::REG_ON_1HZ]   = vbs_pkg::RST_ON_1HZ;
            regs[vbs_pkg::REG_OFF_1HZ]  = vbs_pkg::RST_OFF_1HZ;
            regs[vbs_pkg::REG_ON_2HZ]   = vbs_pkg::RST_ON_2HZ;
            regs[vbs_pkg::REG_OFF_2HZ]  = vbs_pkg::RST_OFF_2HZ;
            regs[vbs_pkg::REG_ON_4HZ]   = vbs_pkg::RST_ON_4HZ;
            regs[vbs_pkg::REG_OFF_4HZ]  = vbs_pkg::RST_OFF_4HZ;
            regs[vbs_pkg::REG_KEEP_ON]  = vbs_pkg::RST_KEEP_ON;
            regs[vbs_pkg::REG_KEEP_OFF] = vbs_pkg::RST_KEEP_OFF;
            clear_burst();
            on_lim  = vbs_pkg::on_cnt_t'(vbs_pkg::RST_ON_1HZ);
            off_lim = vbs_pkg::RST_OFF_1HZ;
            cyc_lim = vbs_pkg::RST_CYCLE_LIMIT;
            errors  = 0;
        endfunction

        function void clear_burst();
            phase_now = vbs_pkg::PH_IDLE;
            on_cnt    = '0;
            off_cnt   = '0;
            cyc_cnt   = '0;
        endfunction

        function void write_register(vbs_pkg::cfg_idx_t idx, vbs_pkg::tick_t val);
            regs[idx] = val;
        endfunction

        // latch the level's limits, or refuse with busy / invalid
        function vbs_pkg::code_t apply_start(vbs_pkg::code_t lvl, vbs_pkg::dur_t dur);
            if (phase_now != vbs_pkg::PH_IDLE)
                return vbs_pkg::ST_BUSY;
            if (dur == '0)
                return vbs_pkg::ST_INVALID;
            case (lvl)
                vbs_pkg::LVL_1HZ:
                begin
                    cyc_lim = vbs_pkg::cycle_t'(dur);
                    on_lim  = vbs_pkg::on_cnt_t'(regs[vbs_pkg::REG_ON_1HZ]);
                    off_lim = regs[vbs_pkg::REG_OFF_1HZ];
                end
                vbs_pkg::LVL_2HZ:
                begin
                    cyc_lim = vbs_pkg::cycle_t'(dur) << 1;
                    on_lim  = vbs_pkg::on_cnt_t'(regs[vbs_pkg::REG_ON_2HZ]);
                    off_lim = regs[vbs_pkg::REG_OFF_2HZ];
                end
                vbs_pkg::LVL_4HZ:
                begin
                    cyc_lim = vbs_pkg::cycle_t'(dur) << 2;
                    on_lim  = vbs_pkg::on_cnt_t'(regs[vbs_pkg::REG_ON_4HZ]);
                    off_lim = regs[vbs_pkg::REG_OFF_4HZ];
                end
                default:
                begin
                    cyc_lim = vbs_pkg::cycle_t'(1);
                    on_lim  = vbs_pkg::on_cnt_t'(regs[vbs_pkg::REG_KEEP_ON])
                            * vbs_pkg::on_cnt_t'(dur);
                    off_lim = regs[vbs_pkg::REG_KEEP_OFF];
                end
            endcase
            on_cnt    = '0;
            off_cnt   = '0;
            cyc_cnt   = '0;
            phase_now = vbs_pkg::PH_ON;
            return vbs_pkg::ST_OK;
        endfunction

        // on count first, then off count, then cycle count
        function void advance_tick();
            case (phase_now)
                vbs_pkg::PH_ON:
                begin
                    on_cnt = on_cnt + 1'b1;
                    if (on_cnt >= on_lim)
                        phase_now = vbs_pkg::PH_OFF;
                end
                vbs_pkg::PH_OFF:
                begin
                    off_cnt = off_cnt + 1'b1;
                    if (off_cnt >= off_lim)
                    begin
                        cyc_cnt = cyc_cnt + 1'b1;
                        if (cyc_cnt >= cyc_lim)
                            clear_burst();
                        else
                        begin
                            on_cnt    = '0;
                            off_cnt   = '0;
                            phase_now = vbs_pkg::PH_ON;
                        end
                    end
                end
                default:
                    clear_burst();
            endcase
        endfunction

        function void note_request(vbs_pkg::req_t r);
            vbs_pkg::rsp_t want;
            want.status = vbs_pkg::ST_OK;
            case (r.req_type)
                vbs_pkg::REQ_TICK:  advance_tick();
                vbs_pkg::REQ_START: want.status = apply_start(r.level, r.duration_sec);
                vbs_pkg::REQ_STOP:  clear_burst();
                default:            ;
            endcase
            want.phase       = phase_now;
            want.motor_drive = (phase_now == vbs_pkg::PH_ON);
            owed_rsp_q.push_back(want);
        endfunction

        function void check_response(vbs_pkg::rsp_t got);
            vbs_pkg::rsp_t want;
            if (owed_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response drive %0b status %0d phase %0d",
                         $time, got.motor_drive, got.status, got.phase);
                errors++;
                return;
            end
            want = owed_rsp_q.pop_front();
            if (got.motor_drive !== want.motor_drive)
            begin
                $display("%0t: motor_drive expected %0b actual %0b",
                         $time, want.motor_drive, got.motor_drive);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.phase !== want.phase)
            begin
                $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
                errors++;
            end
        endfunction

        function int pending();
            return owed_rsp_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vbs_req_if req_ch ();
    vbs_rsp_if rsp_ch ();
    vbs_cfg_if cfg_ch ();

    burst_scoreboard sb = new();

    int send_idle_pct = 0;      // chance per cycle that the sender holds back
    int recv_idle_pct = 0;      // chance per cycle that the receiver stalls
    int hold_requests = 0;      // long receiver stalls asked for so far
    int items_sent    = 0;      // accepted items, ignored codes not counted

    vibration_burst_sequencer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // everything is observed at the edge, before any nonblocking update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_register(cfg_ch.index, cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(vbs_pkg::req_t'({req_ch.req_type, req_ch.level,
                                                 req_ch.duration_sec}));
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(vbs_pkg::rsp_t'({rsp_ch.motor_drive, rsp_ch.status,
                                                   rsp_ch.phase}));
        end
    end

    // response side: random stalls, plus a long hold whenever one is asked for
    initial
    begin : rsp_sink
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_requests > served)
            begin
                served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one item on req; valid stays up afterwards so back-to-back items need no glitch
    task automatic send_request(vbs_pkg::code_t kind, vbs_pkg::code_t lvl,
                                vbs_pkg::dur_t dur);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.level        <= lvl;
        req_ch.duration_sec <= dur;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind != REQ_UNUSED)
            items_sent++;
    endtask

    // write all eight registers back to back, block must be idle
    task automatic program_registers(reg_file_t vals);
        for (int i = 0; i < 8; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= vbs_pkg::cfg_idx_t'(i);
            cfg_ch.data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // stop offering and let every owed response come home
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly short runs, now and then zero or a full 16-bit value
    function automatic vbs_pkg::dur_t start_duration();
        case ($urandom_range(11))
            0:       return '0;
            1:       return vbs_pkg::dur_t'($urandom);
            default: return vbs_pkg::dur_t'($urandom_range(1, 3));
        endcase
    endfunction

    // a start, then a run of ticks with a little noise, sometimes cut by a stop
    task automatic random_burst();
        int n_ticks;
        int pick;
        send_request(vbs_pkg::REQ_START, vbs_pkg::code_t'($urandom_range(3)),
                     start_duration());
        n_ticks = $urandom_range(1, 60);
        repeat (n_ticks)
        begin
            pick = $urandom_range(99);
            if (pick < 88)
                send_request(vbs_pkg::REQ_TICK, vbs_pkg::code_t'($urandom_range(3)),
                             vbs_pkg::dur_t'($urandom));
            else if (pick < 93)
                send_request(vbs_pkg::REQ_START, vbs_pkg::code_t'($urandom_range(3)),
                             start_duration());
            else if (pick < 96)
                send_request(REQ_UNUSED, vbs_pkg::code_t'($urandom_range(3)),
                             vbs_pkg::dur_t'($urandom));
            else
                send_request(vbs_pkg::REQ_STOP, vbs_pkg::code_t'($urandom_range(3)),
                             vbs_pkg::dur_t'($urandom));
        end
        if ($urandom_range(3) == 0)
            send_request(vbs_pkg::REQ_STOP, vbs_pkg::code_t'($urandom_range(3)),
                         vbs_pkg::dur_t'($urandom));
    endtask

    initial
    begin
        reg_file_t setting;
        int        target;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= vbs_pkg::REQ_TICK;
        req_ch.level        <= vbs_pkg::LVL_1HZ;
        req_ch.duration_sec <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= vbs_pkg::REG_ON_1HZ;
        cfg_ch.data         <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset register values (1 Hz is 5 on, 5 off)
        send_request(vbs_pkg::REQ_TICK, vbs_pkg::LVL_1HZ, '0);          // tick while idle
        send_request(REQ_UNUSED, vbs_pkg::LVL_CONT, '1);                // unused code
        send_request(vbs_pkg::REQ_START, vbs_pkg::LVL_1HZ, '0);         // zero duration
        send_request(vbs_pkg::REQ_START, vbs_pkg::LVL_1HZ, vbs_pkg::dur_t'(1)); // one second
        send_request(vbs_pkg::REQ_START, vbs_pkg::LVL_CONT, vbs_pkg::dur_t'(5)); // busy
        repeat (10) send_request(vbs_pkg::REQ_TICK, vbs_pkg::LVL_1HZ, '0); // out to idle
        send_request(vbs_pkg::REQ_STOP, vbs_pkg::LVL_1HZ, '0);          // stop while idle
        send_request(vbs_pkg::REQ_START, vbs_pkg::LVL_4HZ, '1);         // largest, 4x cycles
        repeat (2) send_request(vbs_pkg::REQ_TICK, vbs_pkg::LVL_1HZ, '0); // on, off, on
        send_request(vbs_pkg::REQ_STOP, vbs_pkg::LVL_1HZ, '0);
        send_request(vbs_pkg::REQ_START, vbs_pkg::LVL_CONT, '1);        // largest on time
        send_request(vbs_pkg::REQ_TICK, vbs_pkg::LVL_1HZ, '0);
        send_request(vbs_pkg::REQ_STOP, vbs_pkg::LVL_1HZ, '0);
        send_request(vbs_pkg::REQ_START, vbs_pkg::LVL_2HZ, vbs_pkg::dur_t'(16'h8000));
        send_request(vbs_pkg::REQ_TICK, vbs_pkg::LVL_1HZ, '0);
        send_request(vbs_pkg::REQ_STOP, vbs_pkg::LVL_1HZ, '0);

        // random part: all-zero limits, all-max limits, then small random limits
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            wait_drained();
            foreach (setting[i])
            begin
                if (p == 0)
                    setting[i] = '0;
                else if (p == 1)
                    setting[i] = '1;
                else
                    setting[i] = vbs_pkg::tick_t'($urandom_range(0, 4));
            end
            program_registers(setting);

            // receiver-heavy stalls, then sender-heavy gaps, then full rate
            if (p < 2)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 66;
            end
            else if (p < 4)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // long receiver hold while items keep coming, so the input backs up
            hold_requests++;
            target = items_sent + ITEMS_PER_SET;
            while (items_sent < target)
                random_burst();
        end

        wait_drained();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("simulation failed");
        $finish;
    end

endmodule
